// File: rtl/lomt_pkg.sv
// shared constants, types and control bundles for the last-occurrence mex tree
`timescale 1ns / 1ps
`default_nettype none
package lomt_pkg;

    localparam int LEAVES        = 1024;
    localparam int POSITION_BITS = 20;
    localparam int TREE_DEPTH    = $clog2(LEAVES);
    localparam int PAD_LEAVES    = 1 << TREE_DEPTH;
    localparam int MEM_ROWS      = PAD_LEAVES;

    // fixed field widths of the stream payload
    localparam int VALUE_W     = 10;
    localparam int FIELD_POS_W = 20;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;
    localparam int CMP_W       = (POSITION_BITS > FIELD_POS_W) ? POSITION_BITS : FIELD_POS_W;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [TREE_DEPTH:0]        node_t;
    typedef logic [TREE_DEPTH-1:0]      idx_t;
    typedef logic [POSITION_BITS-1:0]   pos_t;
    typedef logic [2*POSITION_BITS-1:0] row_data_t;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic at_root;
        logic at_leaf;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/lomt_datapath.sv
// tree memory, walk registers and result register of the mex tree
`timescale 1ns / 1ps
`default_nettype none
module lomt_datapath import lomt_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dp_cmd_t                cmd,
    output dp_stat_t                    stat,
    input  wire logic                   in_command,
    input  wire logic [VALUE_W-1:0]     in_value,
    input  wire logic [FIELD_POS_W-1:0] in_position,
    input  wire logic [FIELD_POS_W-1:0] in_begin,
    output logic [VALUE_W-1:0]          result
);

    // row r holds the children 2r (low half) and 2r+1 (high half)
    row_data_t mem [MEM_ROWS];

    idx_t                   clr_cnt_reg, clr_cnt_next;
    node_t                  node_reg, node_next;
    pos_t                   val_reg, val_next;
    logic [FIELD_POS_W-1:0] begin_reg;
    logic                   is_query_reg;
    row_data_t              rd_data_reg;
    logic [VALUE_W-1:0]     result_reg;

    idx_t      rd_row, wr_row, load_idx, leaf_idx;
    pos_t      left_min, right_min, new_left, new_right;
    row_data_t row_new;
    logic      go_left;

    assign left_min  = rd_data_reg[POSITION_BITS-1:0];
    assign right_min = rd_data_reg[2*POSITION_BITS-1:POSITION_BITS];
    assign rd_row    = is_query_reg ? node_reg[TREE_DEPTH-1:0] : node_reg[TREE_DEPTH:1];
    assign wr_row    = node_reg[TREE_DEPTH:1];
    assign go_left   = CMP_W'(left_min) < CMP_W'(begin_reg);

    always_comb begin
        new_left  = node_reg[0] ? left_min : val_reg;
        new_right = node_reg[0] ? val_reg  : right_min;
        row_new   = {new_right, new_left};
    end

    // clamp large values onto the last leaf
    always_comb begin
        if (32'(in_value) > LEAVES - 1) begin
            load_idx = idx_t'(LEAVES - 1);
        end else begin
            load_idx = idx_t'(in_value);
        end
    end

    always_comb begin
        node_next = node_reg;
        val_next  = val_reg;
        if (cmd.load) begin
            node_next = (in_command == CMD_QUERY) ? node_t'(1) : {1'b1, load_idx};
            val_next  = pos_t'(in_position);
        end else if (cmd.step) begin
            if (is_query_reg) begin
                node_next = {node_reg[TREE_DEPTH-1:0], !go_left};
            end else begin
                node_next = node_reg >> 1;
                val_next  = (new_left < new_right) ? new_left : new_right;
            end
        end
    end

    assign clr_cnt_next = cmd.clr_wr ? clr_cnt_reg + idx_t'(1) : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        val_reg  <= val_next;
        if (cmd.load) begin
            begin_reg    <= in_begin;
            is_query_reg <= (in_command == CMD_QUERY);
        end
        if (cmd.out_load) begin
            result_reg <= VALUE_W'(leaf_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.step && !is_query_reg) begin
            mem[wr_row] <= row_new;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    // padding leaves saturate to the last real value
    always_comb begin
        if (32'(node_reg[TREE_DEPTH-1:0]) > LEAVES - 1) begin
            leaf_idx = idx_t'(LEAVES - 1);
        end else begin
            leaf_idx = node_reg[TREE_DEPTH-1:0];
        end
    end

    assign stat.clr_done = (clr_cnt_reg == idx_t'(MEM_ROWS - 1));
    assign stat.is_query = is_query_reg;
    assign stat.at_root  = (node_reg == node_t'(1));
    assign stat.at_leaf  = node_reg[TREE_DEPTH];
    assign result        = result_reg;

endmodule
`default_nettype wire

// File: rtl/lomt_ctrl.sv
// sequencer for clearing, tree updates, descents and the result handshake
`timescale 1ns / 1ps
`default_nettype none
module lomt_ctrl import lomt_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (stat.is_query && stat.at_leaf) begin
                    state_next = ST_OUT;
                end else if (!stat.is_query && stat.at_root) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_READ;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// File: rtl/last_occurrence_mex_tree.sv
// top level of the last-occurrence min-tree with range-mex descent
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tuser command, s_tdata value/pos/begin
//  m_      | out | m_tvalid / m_tready  | m_tdata smallest_value
//
// a record request makes one read and one write of the tree memory per level on
// the way to the root
// a query request makes one memory read and one compare per level on the way
// down, then the result register load
// after reset a clearing pass writes zero to all LEAVES memory rows, one a cycle,
// with s_tready low
// a finished result waits in the output register; the next request is taken
// meanwhile, and only a second result stalls until m_tready frees it
`timescale 1ns / 1ps
`default_nettype none
module last_occurrence_mex_tree import lomt_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[9:0], position[29:10],
                                                 // begin_req[49:30], zeros[55:50]
    input  wire logic                 s_tuser,   // command: 0 record, 1 query
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // smallest_value[9:0], zeros[15:10]
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [VALUE_W-1:0] result;

    // unpack the request fields
    logic [VALUE_W-1:0]     in_value;
    logic [FIELD_POS_W-1:0] in_position;
    logic [FIELD_POS_W-1:0] in_begin;

    assign in_value    = s_tdata[VALUE_W-1:0];
    assign in_position = s_tdata[VALUE_W +: FIELD_POS_W];
    assign in_begin    = s_tdata[VALUE_W + FIELD_POS_W +: FIELD_POS_W];

    // sequencer: clearing pass, level walk, output handshake
    lomt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // tree memory and the per-level compare/min logic
    lomt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_command  (s_tuser),
        .in_value    (in_value),
        .in_position (in_position),
        .in_begin    (in_begin),
        .result      (result)
    );

    assign m_tdata = {{(M_TDATA_W - VALUE_W){1'b0}}, result};

endmodule
`default_nettype wire

// File: rtl/lomt_checker.sv
// port-level checks for the mex tree, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module lomt_checker import lomt_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // no result may be pending right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // the block works on one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a record request never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_RECORD) |=> !$rose(m_tvalid))
        else $error("result raised right after a record request");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind last_occurrence_mex_tree lomt_checker u_lomt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
